>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the date validation block.
// Standalone header; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Combinational property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: invariant violated");
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/dvbe_pkg.sv
// Constants, widths and helper functions for the date validation and BCD encoder.
// No dependencies; used by datetime_validate_bcd_encode.
package dvbe_pkg;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [15:0] YEAR_MIN      = 16'd2000;
    localparam logic [15:0] YEAR_MAX      = 16'd2099;
    localparam logic [7:0]  MONTH_MIN     = 8'd1;
    localparam logic [7:0]  MONTH_MAX     = 8'd12;
    localparam logic [7:0]  DAY_MIN       = 8'd1;
    localparam logic [7:0]  HOUR_MAX      = 8'd23;
    localparam logic [7:0]  MIN_SEC_MAX   = 8'd59;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_MAR     = 4'd3;
    localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;

    // Century terms of Zeller's sum, j/4 + 5j, for j = 20 and j = 19.
    localparam logic [6:0]  CENTURY_20    = 7'd105;
    localparam logic [6:0]  CENTURY_19    = 7'd99;
    // Year-in-century for January and February of 2000 (counted as 1999).
    localparam logic [6:0]  K_PREV_CENT   = 7'd99;

    // Days in a common year, month 1..12.
    function automatic logic [4:0] month_days(input logic [3:0] mo);
        logic [4:0] len;
        case (mo)
            4'd2:                       len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(13 * (mm + 1) / 5) with January and February as months 13 and 14.
    function automatic logic [5:0] zeller_month_term(input logic [3:0] mo);
        logic [5:0] t;
        case (mo)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // Two BCD digits of a value 0..99; v / 10 as (v * 205) >> 11.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  rem;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        rem  = v - 7'(tens) * 7'd10;
        return {tens, rem[3:0]};
    endfunction

    // Weekday code 1 = Monday .. 7 = Sunday from Zeller's sum (0..298).
    // sum / 7 as (sum * 293) >> 11, exact over that range.
    function automatic logic [2:0] weekday_of_sum(input logic [8:0] sum);
        logic [17:0] prod;
        logic [5:0]  q;
        logic [8:0]  h;
        logic [2:0]  wd;
        prod = 18'(sum) * 18'd293;
        q    = prod[16:11];
        h    = sum - 9'(q) * 9'd7;
        // Zeller's 0 is Saturday: shift to Monday-based 1..7.
        if (h[2:0] >= 3'd2) begin
            wd = h[2:0] - 3'd1;
        end else begin
            wd = h[2:0] + 3'd6;
        end
        return wd;
    endfunction

endpackage

>>> hw/rtl/datetime_validate_bcd_encode.sv
// Date/time validator and BCD encoder, three-stage pipeline.
// Depends on dvbe_pkg and assert_macros.svh.
//
// Usage: one binary date and time enters per transfer on the slave stream
// (i_s_*) and exactly one result leaves per transfer on the master stream
// (o_m_*). o_m_tuser[0] is 1 when every field is in range; when it is 0 the
// whole o_m_tdata is zero. The weekday (1 Monday .. 7 Sunday) is computed,
// never taken from the caller.
// An accepted transfer passes the check stage, the BCD/weekday-sum stage and
// the mod-7 output stage, whose register drives o_m_tvalid and o_m_tdata.
// Throughput: one item per cycle while i_m_tready is high; each stage holds one item and its valid bit.
// Reset clears the three valid bits; the block is ready right after reset.
// When the receiver stalls, the output stage holds its result and the stages
// behind it keep filling empty slots, so up to three items are held before
// o_s_tready drops. Nothing is lost or repeated across a stall.
`include "assert_macros.svh"

module datetime_validate_bcd_encode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // year[15:0], month[23:16], day[31:24], hour[39:32], minute[47:40], second[55:48]
    input  logic [dvbe_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // bcd_year[7:0], bcd_month[12:8], bcd_day[18:13], weekday[21:19],
    // bcd_hour[27:22], bcd_minute[34:28], bcd_second[41:35], zero pad[47:42]
    output logic [dvbe_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // accepted[0]
    output logic [0:0]                         o_m_tuser
);

    // Input fields
    logic [15:0] in_year;
    logic [7:0]  in_month, in_day, in_hour, in_minute, in_second;

    // Stage control
    logic r_v1, r_v2, r_v3;
    logic ld1, ld2, ld3;
    logic rdy1, rdy2, rdy3;

    // Stage 1: range checks
    logic       r_ok1;
    logic [6:0] r_yo1;
    logic [3:0] r_mo1;
    logic [4:0] r_day1, r_hr1;
    logic [5:0] r_mi1, r_se1;

    // Stage 2: BCD digits and Zeller sum
    logic       r_ok2;
    logic [7:0] r_byr2;
    logic [4:0] r_bmo2;
    logic [5:0] r_bdy2, r_bhr2;
    logic [6:0] r_bmi2, r_bse2;
    logic [8:0] r_sum2;

    // Stage 3: output register
    logic                           r_acc3;
    logic [dvbe_pkg::OUT_DATA_W-1:0] r_data3;

    // Next values
    logic       n_ok1;
    logic [15:0] n_yo_full;
    logic       yr_ok, mo_ok, dy_ok, tm_ok, leap;
    logic [4:0] mlen;
    logic       early, prev_cent;
    logic [6:0] k_val, j_term;
    logic [7:0] k_sum;
    logic [8:0] n_sum2;
    logic [2:0] n_wd3;
    logic [dvbe_pkg::OUT_DATA_W-1:0] n_data3;

    assign in_year   = i_s_tdata[15:0];
    assign in_month  = i_s_tdata[23:16];
    assign in_day    = i_s_tdata[31:24];
    assign in_hour   = i_s_tdata[39:32];
    assign in_minute = i_s_tdata[47:40];
    assign in_second = i_s_tdata[55:48];

    // A stage takes a new item when empty or when its item moves on.
    assign rdy3 = !r_v3 || i_m_tready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign ld1  = rdy1;
    assign ld2  = rdy2;
    assign ld3  = rdy3;

    assign o_s_tready = rdy1;
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_data3;
    assign o_m_tuser  = r_acc3;

    // Stage 1 logic
    always_comb begin
        yr_ok     = (in_year >= dvbe_pkg::YEAR_MIN) && (in_year <= dvbe_pkg::YEAR_MAX);
        n_yo_full = in_year - dvbe_pkg::YEAR_MIN;
        mo_ok     = (in_month >= dvbe_pkg::MONTH_MIN) && (in_month <= dvbe_pkg::MONTH_MAX);
        // 2000 is divisible by 400, so within the century every 4th year leaps.
        leap      = (n_yo_full[1:0] == 2'd0);
        mlen      = dvbe_pkg::month_days(in_month[3:0]);
        if ((in_month[3:0] == dvbe_pkg::MONTH_FEB) && leap) begin
            mlen = dvbe_pkg::FEB_LEAP_DAYS;
        end
        dy_ok     = (in_day >= dvbe_pkg::DAY_MIN) && (in_day <= 8'(mlen));
        tm_ok     = (in_hour <= dvbe_pkg::HOUR_MAX) && (in_minute <= dvbe_pkg::MIN_SEC_MAX)
                    && (in_second <= dvbe_pkg::MIN_SEC_MAX);
        n_ok1     = yr_ok && mo_ok && dy_ok && tm_ok;
    end

    // Stage 2 logic: Zeller's sum with January/February in the previous year
    always_comb begin
        early     = (r_mo1 < dvbe_pkg::MONTH_MAR);
        prev_cent = early && (r_yo1 == 7'd0);
        if (prev_cent) begin
            k_val  = dvbe_pkg::K_PREV_CENT;
            j_term = dvbe_pkg::CENTURY_19;
        end else if (early) begin
            k_val  = r_yo1 - 7'd1;
            j_term = dvbe_pkg::CENTURY_20;
        end else begin
            k_val  = r_yo1;
            j_term = dvbe_pkg::CENTURY_20;
        end
        k_sum  = 8'(k_val) + 8'(k_val[6:2]);
        n_sum2 = 9'(r_day1) + 9'(dvbe_pkg::zeller_month_term(r_mo1)) + 9'(k_sum)
                 + 9'(j_term);
    end

    // Stage 3 logic: reduce mod 7 and zero a rejected result
    always_comb begin
        n_wd3   = dvbe_pkg::weekday_of_sum(r_sum2);
        n_data3 = {6'd0, r_bse2, r_bmi2, r_bhr2, n_wd3, r_bdy2, r_bmo2, r_byr2};
        if (!r_ok2) begin
            n_data3 = '0;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_s_tvalid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload; hold a stage while it cannot advance
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_ok1  <= n_ok1;
            r_yo1  <= n_yo_full[6:0];
            r_mo1  <= in_month[3:0];
            r_day1 <= in_day[4:0];
            r_hr1  <= in_hour[4:0];
            r_mi1  <= in_minute[5:0];
            r_se1  <= in_second[5:0];
        end
        if (ld2) begin
            r_ok2  <= r_ok1;
            r_byr2 <= dvbe_pkg::to_bcd(r_yo1);
            r_bmo2 <= 5'(dvbe_pkg::to_bcd(7'(r_mo1)));
            r_bdy2 <= 6'(dvbe_pkg::to_bcd(7'(r_day1)));
            r_bhr2 <= 6'(dvbe_pkg::to_bcd(7'(r_hr1)));
            r_bmi2 <= 7'(dvbe_pkg::to_bcd(7'(r_mi1)));
            r_bse2 <= 7'(dvbe_pkg::to_bcd(7'(r_se1)));
            r_sum2 <= n_sum2;
        end
        if (ld3) begin
            r_acc3  <= r_ok2;
            r_data3 <= n_data3;
        end
    end

    `ASSERT_IMPLIES(a_reject_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0)
    `ASSERT_IMPLIES(a_weekday_set, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[21:19] != 3'd0)
    `ASSERT_IMPLIES(a_ready_when_empty, i_clk, i_rst_n, !r_v1, o_s_tready)
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_v3 && !i_m_tready, r_v3 && $stable(r_data3))

endmodule
